FILE: sv/gctg_pkg.sv
// ----------------------------------------------------------------------------
// gctg_pkg
// Shared types, constants and helpers for the collection trigger governor.
// ----------------------------------------------------------------------------
`default_nettype none

package gctg_pkg;

  localparam int DEF_BYTE_BITS     = 48;
  localparam int DEF_SEC_CNT_BITS  = 24;
  localparam int WORK_W            = 64;  // width of intermediate sums/products
  localparam int SEC_BYTES_W       = 25;
  localparam int RATIO_W           = 16;
  localparam int CMD_W             = 3;
  localparam int CFG_IDX_W         = 3;
  localparam int CNT_W             = $clog2(WORK_W);

  localparam logic [SEC_BYTES_W-1:0] SEC_BYTES_RST = SEC_BYTES_W'(1048576);
  localparam logic [RATIO_W-1:0]     RATIO_RST     = RATIO_W'(32768);
  localparam logic [31:0]            MIN_ALLOW_RST = 32'd1384120;

  typedef enum logic [CMD_W-1:0] {
    CMD_MINOR_START = 3'd0,
    CMD_MAJOR_START = 3'd1,
    CMD_MAJOR_END   = 3'd2,
    CMD_SECTIONS    = 3'd3,
    CMD_NEED_QUERY  = 3'd4,
    CMD_ALLOC       = 3'd5,
    CMD_RELEASE     = 3'd6
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECTION_BYTES = 3'd0,
    CFG_MIN_ALLOWANCE = 3'd1,
    CFG_SOFT_LIMIT    = 3'd2,
    CFG_MAX_HEAP      = 3'd3,
    CFG_SAVE_RATIO    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  function automatic logic [WORK_W-1:0] sat_add(input logic [WORK_W-1:0] a,
                                                input logic [WORK_W-1:0] b);
    logic [WORK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORK_W] ? {WORK_W{1'b1}} : s[WORK_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/gctg_alu.sv
// ----------------------------------------------------------------------------
// gctg_alu
// Shared serial unit: 64-step shift-add multiply or restoring divide on one
// adder. Multiply gives {hi,lo} = a*b; divide gives lo = {h,b}/a.
// ----------------------------------------------------------------------------
`default_nettype none

module gctg_alu import gctg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire alu_ctl_t          ctl_i,
  input  wire logic [WORK_W-1:0] a_i,
  input  wire logic [WORK_W-1:0] b_i,
  input  wire logic [WORK_W-1:0] h_i,
  output alu_sts_t               sts_o,
  output logic [WORK_W-1:0]      hi_o,
  output logic [WORK_W-1:0]      lo_o
);

  alu_op_e           op_q;
  logic [WORK_W-1:0] a_q, hi_q, lo_q, hi_d, lo_d, x, opnd;
  logic [WORK_W:0]   sum;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q, is_div, ge;

  always_comb begin
    is_div = (op_q == ALU_DIV);
    x      = is_div ? {hi_q[WORK_W-2:0], lo_q[WORK_W-1]} : hi_q;
    opnd   = is_div ? ~a_q : (lo_q[0] ? a_q : '0);
    sum    = {1'b0, x} + {1'b0, opnd} + (WORK_W+1)'(is_div);
    // divide: remainder overflowed out of the top, or no borrow
    ge     = hi_q[WORK_W-1] || sum[WORK_W];
    if (is_div) begin
      hi_d = ge ? sum[WORK_W-1:0] : x;
      lo_d = {lo_q[WORK_W-2:0], ge};
    end else begin
      hi_d = sum[WORK_W:1];
      lo_d = {sum[0], lo_q[WORK_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(WORK_W-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      op_q <= ctl_i.op;
      a_q  <= a_i;
      lo_q <= b_i;
      hi_q <= (ctl_i.op == ALU_DIV) ? h_i : '0;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign hi_o       = hi_q;
  assign lo_o       = lo_q;

endmodule

`default_nettype wire

FILE: sv/gc_collection_trigger_governor.sv
// ----------------------------------------------------------------------------
// gc_collection_trigger_governor
// Heap budget and minor-allowance governor for a two-generation collector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_stall_o) carries one command beat: cmd_i,
//   amount_i, major_sections_i, los_usage_i, swept_i. Each command yields
//   exactly one result beat on out_valid_o/out_stall_i: verdict_o,
//   allowance_o, free_space_o. One command is handled at a time.
//   Release, alloc, sections and major start finish in the execute state;
//   a need query waits on one serial multiply. A swept recompute on minor
//   start or major end runs five multiplies and one divide (skipped when the
//   quotient saturates) on the single shared serial adder, then the clamp
//   and soft-limit states. While a result beat waits under out_stall_i,
//   in_stall_o stays high and all state holds. The user is to write
//   configuration (cfg_we_i/cfg_idx_i/cfg_data_i) only while idle; the
//   block does not enforce this. Reset loads the default registers, clears
//   heap usage and snapshots, and sets the allowance to the minimum default.
// ----------------------------------------------------------------------------
`default_nettype none

module gc_collection_trigger_governor import gctg_pkg::*; #(
  parameter int BYTE_BITS          = DEF_BYTE_BITS,
  parameter int SECTION_COUNT_BITS = DEF_SEC_CNT_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [BYTE_BITS-1:0]          cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [CMD_W-1:0]              cmd_i,
  input  wire logic [BYTE_BITS-1:0]          amount_i,
  input  wire logic [SECTION_COUNT_BITS-1:0] major_sections_i,
  input  wire logic [BYTE_BITS-1:0]          los_usage_i,
  input  wire logic                          swept_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               verdict_o,
  output logic [BYTE_BITS-1:0]               allowance_o,
  output logic [BYTE_BITS-1:0]               free_space_o
);

  localparam int B = BYTE_BITS;
  localparam int S = SECTION_COUNT_BITS;
  localparam logic [WORK_W-1:0] BMAX = WORK_W'({B{1'b1}});
  localparam logic [B:0]        SMAX = (B+1)'({S{1'b1}});

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_QUERY, ST_NMAJ, ST_SAVE, ST_NUM, ST_DEN,
    ST_PROD, ST_DIV, ST_CLAMP, ST_SOFT
  } state_e;

  state_e state_q;

  cmd_e                   cmd_q;
  logic [B-1:0]           amt_q, los_q;
  logic [S-1:0]           nms_q;
  logic                   swept_q;

  logic [SEC_BYTES_W-1:0] sec_bytes_q;
  logic [RATIO_W-1:0]     ratio_q;
  logic [B-1:0]           min_allow_q, soft_q, max_heap_q;
  logic [B-1:0]           heap_q, allow_q, los_after_q, los_before_q, los_grown_q;
  logic [S-1:0]           ssm_q, old_ms_q;
  logic                   pending_q, out_valid_q, verdict_q;

  logic [WORK_W-1:0]      maj_bytes_q, new_heap_q, save_tgt_q, num_q, den_q, target_q;

  alu_ctl_t               alu_ctl_q;
  alu_sts_t               alu_sts;
  logic [WORK_W-1:0]      alu_a_q, alu_b_q, alu_h_q, alu_hi, alu_lo;

  logic [B-1:0]           free_b, grown, los_saved;
  logic [S-1:0]           saved_sec;
  logic [B:0]             ssm_sum;
  logic [WORK_W-1:0]      sb64, nmaj_d, nheap_d, used, clamp_a, soft_sum, soft_a;

  gctg_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl_q),
    .a_i    (alu_a_q),
    .b_i    (alu_b_q),
    .h_i    (alu_h_q),
    .sts_o  (alu_sts),
    .hi_o   (alu_hi),
    .lo_o   (alu_lo)
  );

  always_comb begin
    free_b    = max_heap_q - ((heap_q < max_heap_q) ? heap_q : max_heap_q);
    grown     = los_q - ((los_after_q < los_q) ? los_after_q : los_q);
    los_saved = (los_before_q > los_after_q) ? (los_before_q - los_after_q) : B'(1);
    saved_sec = (old_ms_q > nms_q) ? (old_ms_q - nms_q) : '0;
    ssm_sum   = (B+1)'(ssm_q) + (B+1)'(amt_q);
    sb64      = WORK_W'(sec_bytes_q);
    nmaj_d    = alu_lo;
    nheap_d   = sat_add(alu_lo, WORK_W'(los_after_q));
    used      = sat_add(alu_lo, WORK_W'(grown));
    // min against current heap, then floor at minimum allowance
    clamp_a   = sat_add(maj_bytes_q, WORK_W'(los_q));
    clamp_a   = (target_q < clamp_a) ? target_q : clamp_a;
    clamp_a   = (clamp_a > WORK_W'(min_allow_q)) ? clamp_a : WORK_W'(min_allow_q);
    soft_sum  = sat_add(new_heap_q, target_q);
    soft_a    = target_q;
    if (soft_sum > WORK_W'(soft_q)) begin
      if (new_heap_q > WORK_W'(soft_q)) begin
        soft_a = WORK_W'(min_allow_q);
      end else begin
        soft_a = WORK_W'(soft_q) - new_heap_q;
        soft_a = (soft_a > WORK_W'(min_allow_q)) ? soft_a : WORK_W'(min_allow_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      verdict_q    <= 1'b0;
      alu_ctl_q    <= '{start: 1'b0, op: ALU_MUL};
      sec_bytes_q  <= SEC_BYTES_RST;
      min_allow_q  <= B'(MIN_ALLOW_RST);
      soft_q       <= '1;
      max_heap_q   <= '1;
      ratio_q      <= RATIO_RST;
      heap_q       <= '0;
      allow_q      <= B'(MIN_ALLOW_RST);
      ssm_q        <= '0;
      pending_q    <= 1'b0;
      old_ms_q     <= '0;
      los_after_q  <= '0;
      los_before_q <= '0;
      los_grown_q  <= '0;
    end else begin
      alu_ctl_q.start <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SECTION_BYTES: sec_bytes_q <= cfg_data_i[SEC_BYTES_W-1:0];
          CFG_MIN_ALLOWANCE: min_allow_q <= cfg_data_i;
          CFG_SOFT_LIMIT:    soft_q      <= cfg_data_i;
          CFG_MAX_HEAP:      max_heap_q  <= cfg_data_i;
          CFG_SAVE_RATIO:    ratio_q     <= cfg_data_i[RATIO_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b1;
          verdict_q   <= 1'b0;
          case (cmd_q)
            CMD_MINOR_START, CMD_MAJOR_END: begin
              if (pending_q && swept_q) begin
                state_q     <= ST_NMAJ;
                out_valid_q <= 1'b0;
                alu_ctl_q   <= '{start: 1'b1, op: ALU_MUL};
                alu_a_q     <= WORK_W'(nms_q);
                alu_b_q     <= sb64;
              end else if (cmd_q == CMD_MAJOR_END) begin
                if (pending_q) begin
                  allow_q <= min_allow_q;
                end
                ssm_q       <= '0;
                los_after_q <= los_q;
              end
            end
            CMD_MAJOR_START: begin
              old_ms_q     <= nms_q;
              los_grown_q  <= grown;
              los_before_q <= los_q;
              pending_q    <= 1'b1;
            end
            CMD_SECTIONS: begin
              ssm_q <= (ssm_sum > SMAX) ? {S{1'b1}} : ssm_sum[S-1:0];
            end
            CMD_NEED_QUERY: begin
              state_q     <= ST_QUERY;
              out_valid_q <= 1'b0;
              alu_ctl_q   <= '{start: 1'b1, op: ALU_MUL};
              alu_a_q     <= WORK_W'(ssm_q);
              alu_b_q     <= sb64;
            end
            CMD_ALLOC: begin
              if (free_b >= amt_q) begin
                heap_q    <= heap_q + amt_q;
                verdict_q <= 1'b1;
              end
            end
            CMD_RELEASE: begin
              heap_q <= (heap_q > amt_q) ? (heap_q - amt_q) : '0;
            end
            default: ;
          endcase
        end
        ST_QUERY: begin
          if (alu_sts.done) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            verdict_q   <= (amt_q > free_b) || (used > WORK_W'(allow_q));
          end
        end
        ST_NMAJ: begin
          if (alu_sts.done) begin
            state_q   <= ST_SAVE;
            alu_ctl_q <= '{start: 1'b1, op: ALU_MUL};
            alu_a_q   <= nheap_d;
            alu_b_q   <= WORK_W'(ratio_q);
          end
        end
        ST_SAVE: begin
          if (alu_sts.done) begin
            state_q   <= ST_NUM;
            alu_ctl_q <= '{start: 1'b1, op: ALU_MUL};
            alu_a_q   <= WORK_W'(ssm_q);
            alu_b_q   <= sb64;
          end
        end
        ST_NUM: begin
          if (alu_sts.done) begin
            state_q   <= ST_DEN;
            alu_ctl_q <= '{start: 1'b1, op: ALU_MUL};
            alu_a_q   <= WORK_W'(saved_sec);
            alu_b_q   <= sb64;
          end
        end
        ST_DEN: begin
          if (alu_sts.done) begin
            state_q   <= ST_PROD;
            alu_ctl_q <= '{start: 1'b1, op: ALU_MUL};
            alu_a_q   <= save_tgt_q;
            alu_b_q   <= num_q;
          end
        end
        ST_PROD: begin
          if (alu_sts.done) begin
            if (alu_hi >= den_q) begin
              state_q <= ST_CLAMP;
            end else begin
              state_q   <= ST_DIV;
              alu_ctl_q <= '{start: 1'b1, op: ALU_DIV};
              alu_a_q   <= den_q;
              alu_b_q   <= alu_lo;
              alu_h_q   <= alu_hi;
            end
          end
        end
        ST_DIV: begin
          if (alu_sts.done) begin
            state_q <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          state_q <= ST_SOFT;
        end
        ST_SOFT: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b1;
          verdict_q   <= 1'b0;
          allow_q     <= soft_a[B-1:0];
          pending_q   <= 1'b0;
          if (cmd_q == CMD_MAJOR_END) begin
            ssm_q       <= '0;
            los_after_q <= los_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath holding registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i && !in_stall_o) begin
      cmd_q   <= cmd_e'(cmd_i);
      amt_q   <= amount_i;
      nms_q   <= major_sections_i;
      los_q   <= los_usage_i;
      swept_q <= swept_i;
    end
    if (alu_sts.done) begin
      case (state_q)
        ST_NMAJ: begin
          maj_bytes_q <= nmaj_d;
          new_heap_q  <= nheap_d;
        end
        ST_SAVE: save_tgt_q <= {alu_hi[RATIO_W-1:0], alu_lo[WORK_W-1:RATIO_W]};
        ST_NUM:  num_q      <= sat_add(alu_lo, WORK_W'(los_grown_q));
        ST_DEN:  den_q      <= sat_add(alu_lo, WORK_W'(los_saved));
        ST_PROD: target_q   <= BMAX;
        ST_DIV:  target_q   <= (alu_lo > BMAX) ? BMAX : alu_lo;
        default: ;
      endcase
    end
    if (state_q == ST_CLAMP) begin
      target_q <= clamp_a;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE) || out_valid_q;
  assign out_valid_o  = out_valid_q;
  assign verdict_o    = verdict_q;
  assign allowance_o  = allow_q;
  assign free_space_o = free_b;

  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_stall_o)
    else $error("input open while a result beat is pending");

  a_alu_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_ctl_q.start |-> !alu_sts.busy)
    else $error("serial unit restarted while busy");

  a_recompute_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SOFT) |=> (!pending_q && out_valid_q))
    else $error("recompute did not retire");

endmodule

`default_nettype wire
